>>> hdl/obdrpm_pkg.sv
`timescale 1ns / 1ps

package obdrpm_pkg;

    // field widths
    localparam int unsigned ByteW    = 8;
    localparam int unsigned RpmW     = 14;
    localparam int unsigned CodeW    = 16;
    localparam int unsigned CountW   = 3;
    localparam int unsigned CfgAddrW = 2;
    localparam int unsigned CfgDataW = 32;

    // register map
    localparam logic [CfgAddrW-1:0] AddrMaxRpm = 2'd0;
    localparam logic [RpmW-1:0]     MaxRpmReset = 14'd6500;

    // record pattern length ("410C")
    localparam logic [CountW-1:0] PatLen = 3'd4;
    localparam logic [CountW-1:0] HexLen = 3'd4;

    // characters of interest
    localparam logic [ByteW-1:0] ChPrompt = 8'h3E;
    localparam logic [ByteW-1:0] ChCr     = 8'h0D;
    localparam logic [ByteW-1:0] ChLf     = 8'h0A;
    localparam logic [ByteW-1:0] ChSpace  = 8'h20;
    localparam logic [ByteW-1:0] ChTab    = 8'h09;
    localparam logic [ByteW-1:0] ChVt     = 8'h0B;
    localparam logic [ByteW-1:0] ChFf     = 8'h0C;

    typedef enum logic [2:0] {
        ST_OK        = 3'd0,
        ST_RANGE     = 3'd1,
        ST_BAD_HEX   = 3'd2,
        ST_NO_RECORD = 3'd3,
        ST_EMPTY     = 3'd4
    } t_status;

    typedef struct packed {
        t_status         status;
        logic [RpmW-1:0] rpm;
    } t_result;

    // n-th character of the record pattern
    function automatic logic [ByteW-1:0] pat_char(input logic [1:0] idx);
        logic [ByteW-1:0] c;
        case (idx)
            2'd0:    c = 8'h34; // '4'
            2'd1:    c = 8'h31; // '1'
            2'd2:    c = 8'h30; // '0'
            default: c = 8'h43; // 'C'
        endcase
        return c;
    endfunction

    // lower-case letters to upper case
    function automatic logic [ByteW-1:0] fold_upper(input logic [ByteW-1:0] c);
        logic [ByteW-1:0] r;
        if (c >= 8'h61 && c <= 8'h7A) begin
            r = c - 8'd32;
        end else begin
            r = c;
        end
        return r;
    endfunction

    // hex digit value, msb set when not a digit
    function automatic logic [4:0] hex_value(input logic [ByteW-1:0] c);
        logic [4:0] v;
        if (c >= 8'h30 && c <= 8'h39) begin
            v = {1'b0, c[3:0]};
        end else if (c >= 8'h41 && c <= 8'h46) begin
            v = {1'b0, c[3:0] + 4'd9};
        end else begin
            v = 5'h10;
        end
        return v;
    endfunction

endpackage

>>> hdl/obdrpm_chan_if.sv
`timescale 1ns / 1ps

// input channel: one received character per item
interface obdrpm_in_if;
    logic                          valid;
    logic                          ready;
    logic [obdrpm_pkg::ByteW-1:0]  rx_byte;

    modport source (output valid, output rx_byte, input ready);
    modport sink   (input valid, input rx_byte, output ready);
endinterface

// result channel: one status per line end
interface obdrpm_out_if;
    logic                         valid;
    logic                         ready;
    obdrpm_pkg::t_status          status;
    logic [obdrpm_pkg::RpmW-1:0]  rpm;

    modport source (output valid, output status, output rpm, input ready);
    modport sink   (input valid, input status, input rpm, output ready);
endinterface

>>> hdl/obd_rpm_ascii_response_parser.sv
`timescale 1ns / 1ps

// channel   dir  payload               item
// i_rx      in   rx_byte[7:0]          one response character
// o_res     out  status[2:0] rpm[13:0] one report per line end
// apb       in   max_rpm at 0x0        limit for ok status
//
// one character is taken every cycle while the skid is empty; a line end's report
// is registered from the line state registers into the result register or skid.
// a two-entry output (result register plus skid) lets input continue
// while a report waits; i_rx.ready drops only when both entries are full.
// i_rst_n is synchronous, active low; it clears line state and max_rpm=6500.

module obd_rpm_ascii_response_parser (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    obdrpm_in_if.sink                             i_rx,
    obdrpm_out_if.source                          o_res,
    input  logic                                  psel,
    input  logic                                  penable,
    input  logic                                  pwrite,
    input  logic [obdrpm_pkg::CfgAddrW-1:0]       paddr,
    input  logic [obdrpm_pkg::CfgDataW-1:0]       pwdata,
    output logic [obdrpm_pkg::CfgDataW-1:0]       prdata,
    output logic                                  pready
);

    logic [obdrpm_pkg::RpmW-1:0]   r_max_rpm;
    logic [obdrpm_pkg::CountW-1:0] r_match, n_match;
    logic [obdrpm_pkg::CountW-1:0] r_hex_cnt, n_hex_cnt;
    logic [obdrpm_pkg::CodeW-1:0]  r_code, n_code;
    logic                          r_hex_bad, n_hex_bad;
    logic                          r_has_text, n_has_text;

    obdrpm_pkg::t_result           r_out, r_skid, n_res;
    logic                          r_out_v, r_skid_v;

    logic                          in_acc;
    logic                          is_end;
    logic                          push;
    logic                          pop;
    logic [obdrpm_pkg::ByteW-1:0]  ch;
    logic [obdrpm_pkg::ByteW-1:0]  up;
    logic [4:0]                    hv;
    logic [obdrpm_pkg::RpmW-1:0]   rpm_val;

    // apb register port
    assign pready = 1'b1;
    assign prdata = {{(obdrpm_pkg::CfgDataW - obdrpm_pkg::RpmW){1'b0}}, r_max_rpm};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_rpm <= obdrpm_pkg::MaxRpmReset;
        end else if (psel && penable && pwrite && paddr == obdrpm_pkg::AddrMaxRpm) begin
            r_max_rpm <= pwdata[obdrpm_pkg::RpmW-1:0];
        end
    end

    // handshake
    assign i_rx.ready = !r_skid_v;
    assign in_acc     = i_rx.valid && !r_skid_v;
    assign pop        = r_out_v && o_res.ready;

    assign ch      = i_rx.rx_byte;
    assign up      = obdrpm_pkg::fold_upper(ch);
    assign hv      = obdrpm_pkg::hex_value(up);
    assign rpm_val = r_code[obdrpm_pkg::CodeW-1:2];
    assign is_end  = (ch == obdrpm_pkg::ChPrompt) || (ch == obdrpm_pkg::ChCr)
                  || (ch == obdrpm_pkg::ChLf);
    assign push    = in_acc && is_end;

    // report for a line end
    always_comb begin
        n_res.rpm = '0;
        if (!r_has_text) begin
            n_res.status = obdrpm_pkg::ST_EMPTY;
        end else if (r_match < obdrpm_pkg::PatLen || r_hex_cnt < obdrpm_pkg::HexLen) begin
            n_res.status = obdrpm_pkg::ST_NO_RECORD;
        end else if (r_hex_bad) begin
            n_res.status = obdrpm_pkg::ST_BAD_HEX;
        end else begin
            n_res.rpm    = rpm_val;
            n_res.status = (rpm_val <= r_max_rpm) ? obdrpm_pkg::ST_OK
                                                  : obdrpm_pkg::ST_RANGE;
        end
    end

    // line state update for one character
    always_comb begin
        n_match    = r_match;
        n_hex_cnt  = r_hex_cnt;
        n_code     = r_code;
        n_hex_bad  = r_hex_bad;
        n_has_text = r_has_text;
        if (is_end) begin
            n_match    = '0;
            n_hex_cnt  = '0;
            n_code     = '0;
            n_hex_bad  = 1'b0;
            n_has_text = 1'b0;
        end else begin
            if (ch != obdrpm_pkg::ChSpace && ch != obdrpm_pkg::ChTab
                    && ch != obdrpm_pkg::ChVt && ch != obdrpm_pkg::ChFf) begin
                n_has_text = 1'b1;
            end
            if (ch != obdrpm_pkg::ChSpace) begin
                if (r_match < obdrpm_pkg::PatLen) begin
                    if (up == obdrpm_pkg::pat_char(r_match[1:0])) begin
                        n_match = r_match + 3'd1;
                    end else if (up == obdrpm_pkg::pat_char(2'd0)) begin
                        n_match = 3'd1;
                    end else begin
                        n_match = '0;
                    end
                end else if (r_hex_cnt < obdrpm_pkg::HexLen) begin
                    if (hv[4]) begin
                        n_hex_bad = 1'b1;
                        n_code    = {r_code[obdrpm_pkg::CodeW-5:0], 4'h0};
                    end else begin
                        n_code    = {r_code[obdrpm_pkg::CodeW-5:0], hv[3:0]};
                    end
                    n_hex_cnt = r_hex_cnt + 3'd1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_match    <= '0;
            r_hex_cnt  <= '0;
            r_code     <= '0;
            r_hex_bad  <= 1'b0;
            r_has_text <= 1'b0;
        end else if (in_acc) begin
            r_match    <= n_match;
            r_hex_cnt  <= n_hex_cnt;
            r_code     <= n_code;
            r_hex_bad  <= n_hex_bad;
            r_has_text <= n_has_text;
        end
    end

    // result register with skid entry
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_v  <= 1'b0;
            r_skid_v <= 1'b0;
        end else if (!r_out_v || pop) begin
            if (r_skid_v) begin
                r_out_v  <= 1'b1;
                r_skid_v <= 1'b0;
            end else begin
                r_out_v  <= push;
            end
        end else if (push) begin
            r_skid_v <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!r_out_v || pop) begin
            if (r_skid_v) begin
                r_out <= r_skid;
            end else if (push) begin
                r_out <= n_res;
            end
        end else if (push) begin
            r_skid <= n_res;
        end
    end

    assign o_res.valid  = r_out_v;
    assign o_res.status = r_out.status;
    assign o_res.rpm    = r_out.rpm;

endmodule
